[hw/rtl/ordered_list_intern_table_macros.svh]
// Assertion helpers for the intern table
`ifndef ORDERED_LIST_INTERN_TABLE_MACROS_SVH
`define ORDERED_LIST_INTERN_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define OLIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define OLIT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OLIT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OLIT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/olit_pkg.sv]
package olit_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND    = 2'd0;
    localparam logic [1:0] STATUS_ADDED    = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    localparam int SITE_W      = 8;
    localparam int NUM_SITES_W = 5;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;

    // Control flags that travel with each element down the chain
    typedef struct packed {
        logic valid;     // slot holds an element
        logic last;      // final element of its list
        logic drop;      // element beyond the element bound, not compared
        logic overlong;  // on last: the list exceeded the bound
        logic found;     // on last: an earlier entry matched
        logic claimed;   // the first free cell has taken this list
    } token_ctrl_t;

endpackage

[hw/rtl/ordered_list_intern_table.sv]
// Ordered list intern table.
// The query channel (query_valid/query_ready) takes one site number per
// transaction; last marks the final element of a list. For each list one
// result transaction (result_valid/result_ready) returns list_index and
// status: found, added, table full or list too long. Entry 0 is the list
// 1..num_sites capped at MAX_ELEMS elements, set through
// num_sites_we/num_sites while idle. Elements travel down a chain of
// MAX_LISTS-1 cells, one cell per stored entry, one step per cycle while
// no result is held. A new element is taken every cycle unless a held
// result stalls the chain; a list's result passes through the input
// stage, the cell chain and the output register. Lists follow one another
// without gaps. A result held by a stalled receiver freezes the whole
// chain, and query_ready stays low until it is taken.
// Reset empties the table (only entry 0 remains), clears any partial list
// and sets num_sites to 1; no clearing pass is needed, since each cell has
// its own valid flag.
module ordered_list_intern_table #(
    parameter int MAX_LISTS = 64,
    parameter int MAX_ELEMS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               query_valid,
    output logic                               query_ready,
    input  logic [olit_pkg::SITE_W-1:0]        site_number,
    input  logic                               last,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [olit_pkg::INDEX_W-1:0]       list_index,
    output logic [olit_pkg::STATUS_W-1:0]      status,
    input  logic                               num_sites_we,
    input  logic [olit_pkg::NUM_SITES_W-1:0]   num_sites
);

    localparam int PW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int IW = $clog2(MAX_LISTS);
    localparam int N  = MAX_LISTS - 1;

    logic [olit_pkg::NUM_SITES_W-1:0] num_sites_reg;
    logic                             result_valid_reg;
    logic [olit_pkg::INDEX_W-1:0]     list_index_reg;
    logic [olit_pkg::STATUS_W-1:0]    status_reg;

    logic advance;
    logic take;

    olit_pkg::token_ctrl_t       chain_ctrl [N+1];
    logic [olit_pkg::SITE_W-1:0] chain_site [N+1];
    logic [PW-1:0]               chain_pos  [N+1];
    logic [IW-1:0]               chain_idx  [N+1];

    olit_pkg::token_ctrl_t tail;

    // Chain moves unless a result is held
    assign advance     = !result_valid_reg || result_ready;
    assign query_ready = advance;
    assign take        = query_valid && advance;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sites_reg <= olit_pkg::NUM_SITES_W'(1);
        end
        else if (num_sites_we)
        begin
            num_sites_reg <= num_sites;
        end
    end

    olit_head #(
        .MAX_LISTS (MAX_LISTS),
        .MAX_ELEMS (MAX_ELEMS)
    ) u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .take      (take),
        .site      (site_number),
        .last      (last),
        .num_sites (num_sites_reg),
        .ctrl_out  (chain_ctrl[0]),
        .site_out  (chain_site[0]),
        .pos_out   (chain_pos[0]),
        .idx_out   (chain_idx[0])
    );

    // One cell per stored entry
    for (genvar k = 1; k <= N; k++)
    begin : g_cell
        olit_cell #(
            .MAX_LISTS  (MAX_LISTS),
            .MAX_ELEMS  (MAX_ELEMS),
            .CELL_INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .ctrl_in  (chain_ctrl[k-1]),
            .site_in  (chain_site[k-1]),
            .pos_in   (chain_pos[k-1]),
            .idx_in   (chain_idx[k-1]),
            .ctrl_out (chain_ctrl[k]),
            .site_out (chain_site[k]),
            .pos_out  (chain_pos[k]),
            .idx_out  (chain_idx[k])
        );
    end

    assign tail = chain_ctrl[N];

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= tail.valid && tail.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail.valid && tail.last)
        begin
            if (tail.overlong)
            begin
                status_reg     <= olit_pkg::STATUS_TOO_LONG;
                list_index_reg <= '0;
            end
            else if (tail.found)
            begin
                status_reg     <= olit_pkg::STATUS_FOUND;
                list_index_reg <= olit_pkg::INDEX_W'(chain_idx[N]);
            end
            else if (tail.claimed)
            begin
                status_reg     <= olit_pkg::STATUS_ADDED;
                list_index_reg <= olit_pkg::INDEX_W'(chain_idx[N]);
            end
            else
            begin
                status_reg     <= olit_pkg::STATUS_FULL;
                list_index_reg <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign list_index   = list_index_reg;
    assign status       = status_reg;

    // Checks
`include "ordered_list_intern_table_macros.svh"

    `OLIT_ASSERT_IMP(a_err_index_zero, clk, rst_n, result_valid && (status == olit_pkg::STATUS_FULL || status == olit_pkg::STATUS_TOO_LONG), list_index == '0)
    `OLIT_ASSERT_IMP(a_stall_blocks_query, clk, rst_n, result_valid && !result_ready, !query_ready)
    `OLIT_ASSERT_NXT(a_stall_holds_chain, clk, rst_n, result_valid && !result_ready, tail == $past(tail))

endmodule

[hw/rtl/olit_head.sv]
module olit_head #(
    parameter int MAX_LISTS = 64,
    parameter int MAX_ELEMS = 16,
    localparam int PW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1,
    localparam int LW = $clog2(MAX_ELEMS + 1),
    localparam int IW = $clog2(MAX_LISTS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                take,
    input  logic [olit_pkg::SITE_W-1:0]         site,
    input  logic                                last,
    input  logic [olit_pkg::NUM_SITES_W-1:0]    num_sites,
    output olit_pkg::token_ctrl_t               ctrl_out,
    output logic [olit_pkg::SITE_W-1:0]         site_out,
    output logic [PW-1:0]                       pos_out,
    output logic [IW-1:0]                       idx_out
);

    logic [LW-1:0] qlen_reg;
    logic          overlong_reg;
    logic          def_match_reg;

    olit_pkg::token_ctrl_t              ctrl_reg;
    logic [olit_pkg::SITE_W-1:0]        site_reg;
    logic [PW-1:0]                      pos_reg;

    logic       drop;
    logic       ovl;
    logic       def_cur;
    logic       def_hit;
    logic [8:0] pos_plus1;
    logic [8:0] def_len;

    // Query length bookkeeping and running compare against the default list
    always_comb
    begin
        drop      = (qlen_reg >= LW'(MAX_ELEMS));
        ovl       = overlong_reg | drop;
        pos_plus1 = 9'(qlen_reg) + 9'd1;
        def_cur   = ((qlen_reg == '0) ? 1'b1 : def_match_reg) && ({1'b0, site} == pos_plus1);
        // default list length saturates at the element bound
        def_len   = (9'(num_sites) > 9'(MAX_ELEMS)) ? 9'(MAX_ELEMS) : 9'(num_sites);
        def_hit   = !ovl && def_cur && (def_len == pos_plus1);
    end

    // Query state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            overlong_reg  <= 1'b0;
            def_match_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                qlen_reg     <= '0;
                overlong_reg <= 1'b0;
            end
            else if (!drop)
            begin
                qlen_reg      <= qlen_reg + LW'(1);
                def_match_reg <= def_cur;
            end
            else
            begin
                overlong_reg <= 1'b1;
            end
        end
    end

    // Token control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg.valid    <= take;
            ctrl_reg.last     <= last;
            ctrl_reg.drop     <= drop;
            ctrl_reg.overlong <= last & ovl;
            ctrl_reg.found    <= last & def_hit;
            ctrl_reg.claimed  <= 1'b0;
        end
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            site_reg <= site;
            pos_reg  <= PW'(qlen_reg);
        end
    end

    assign ctrl_out = ctrl_reg;
    assign site_out = site_reg;
    assign pos_out  = pos_reg;
    assign idx_out  = '0;

endmodule

[hw/rtl/olit_cell.sv]
module olit_cell #(
    parameter int MAX_LISTS  = 64,
    parameter int MAX_ELEMS  = 16,
    parameter int CELL_INDEX = 1,
    localparam int PW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1,
    localparam int LW = $clog2(MAX_ELEMS + 1),
    localparam int IW = $clog2(MAX_LISTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  olit_pkg::token_ctrl_t         ctrl_in,
    input  logic [olit_pkg::SITE_W-1:0]   site_in,
    input  logic [PW-1:0]                 pos_in,
    input  logic [IW-1:0]                 idx_in,
    output olit_pkg::token_ctrl_t         ctrl_out,
    output logic [olit_pkg::SITE_W-1:0]   site_out,
    output logic [PW-1:0]                 pos_out,
    output logic [IW-1:0]                 idx_out
);

    // Entry held by this cell
    logic                        valid_reg;
    logic [LW-1:0]               len_reg;
    logic [olit_pkg::SITE_W-1:0] elem_reg [MAX_ELEMS];
    logic                        match_reg;

    olit_pkg::token_ctrl_t       ctrl_reg;
    logic [olit_pkg::SITE_W-1:0] site_reg;
    logic [PW-1:0]               pos_reg;
    logic [IW-1:0]               idx_reg;

    logic cur;
    logic len_eq;
    logic hit;
    logic claim;
    olit_pkg::token_ctrl_t ctrl_next;
    logic [IW-1:0]         idx_next;

    // Element compare and hand-on to the next cell
    always_comb
    begin
        cur    = ((pos_in == '0) ? 1'b1 : match_reg) && (elem_reg[pos_in] == site_in);
        len_eq = (9'(len_reg) == 9'(pos_in) + 9'd1);
        hit    = valid_reg && cur && len_eq && ctrl_in.last && !ctrl_in.drop
                 && !ctrl_in.overlong;
        // first free cell takes the list in case nothing matches
        claim  = !valid_reg && !ctrl_in.claimed;

        ctrl_next         = ctrl_in;
        ctrl_next.found   = ctrl_in.found | hit;
        ctrl_next.claimed = ctrl_in.claimed | claim;
        idx_next          = idx_in;
        if (!ctrl_in.found && (hit || claim))
        begin
            idx_next = IW'(CELL_INDEX);
        end
    end

    // Entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance && ctrl_in.valid && claim && ctrl_in.last
                 && !ctrl_in.found && !ctrl_in.overlong)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl_in.valid)
        begin
            if (!ctrl_in.drop)
            begin
                match_reg <= cur;
            end
            if (claim && !ctrl_in.drop)
            begin
                elem_reg[pos_in] <= site_in;
            end
            if (claim && ctrl_in.last && !ctrl_in.found && !ctrl_in.overlong)
            begin
                len_reg <= LW'(pos_in) + LW'(1);
            end
        end
    end

    // Token registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            site_reg <= site_in;
            pos_reg  <= pos_in;
            idx_reg  <= idx_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign site_out = site_reg;
    assign pos_out  = pos_reg;
    assign idx_out  = idx_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_LISTS    = 64;
    localparam int MAX_ELEMS    = 16;
    localparam int LONGEST_LIST = MAX_ELEMS + 4;
    localparam int LIB_DEPTH    = 256;
    localparam int RANDOM_ITEMS = 1850;
    localparam int NUM_PHASES   = 8;
    // result passes through the head, every cell and the output register
    localparam int DRAIN_CYCLES = MAX_LISTS + 16;

    typedef struct packed {
        logic [olit_pkg::INDEX_W-1:0]  index;
        logic [olit_pkg::STATUS_W-1:0] code;
    } intern_result_t;

    // Predicts the interned index and status of each list, and checks results
    class intern_scoreboard;
        logic [olit_pkg::NUM_SITES_W-1:0] sites;
        int                               entry_total;
        logic [olit_pkg::SITE_W-1:0]      stored [MAX_LISTS][MAX_ELEMS];
        int                               stored_len [MAX_LISTS];
        logic [olit_pkg::SITE_W-1:0]      query [$];
        bit                               overlong;
        intern_result_t                   awaited [$];
        int                               errors;
        int                               elements;
        int                               tally [4];

        function new();
            sites = 1;
            entry_total = 1;
            overlong = 0;
            errors = 0;
            elements = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        // entry 0 is 1..num_sites, saturated at the element bound
        function bit same_as_default();
            int n;
            n = (sites > MAX_ELEMS) ? MAX_ELEMS : int'(sites);
            if (n != query.size()) return 0;
            for (int i = 0; i < n; i++)
                if (query[i] != olit_pkg::SITE_W'(i + 1)) return 0;
            return 1;
        endfunction

        function bit same_as_entry(int e);
            if (stored_len[e] != query.size()) return 0;
            foreach (query[i])
                if (stored[e][i] != query[i]) return 0;
            return 1;
        endfunction

        function void note_element(logic [olit_pkg::SITE_W-1:0] site, logic closes);
            intern_result_t r;
            bit             hit;
            elements++;
            if (query.size() < MAX_ELEMS) query.push_back(site);
            else overlong = 1;
            if (!closes) return;
            r.index = '0;
            hit = 0;
            if (overlong)
                r.code = olit_pkg::STATUS_TOO_LONG;
            else
            begin
                if (same_as_default()) hit = 1;
                // first match in index order wins
                for (int e = 1; !hit && e < entry_total; e++)
                begin
                    if (same_as_entry(e))
                    begin
                        hit = 1;
                        r.index = olit_pkg::INDEX_W'(e);
                    end
                end
                if (hit)
                    r.code = olit_pkg::STATUS_FOUND;
                else if (entry_total >= MAX_LISTS)
                    r.code = olit_pkg::STATUS_FULL;
                else
                begin
                    r.index = olit_pkg::INDEX_W'(entry_total);
                    foreach (query[i]) stored[entry_total][i] = query[i];
                    stored_len[entry_total] = query.size();
                    entry_total++;
                    r.code = olit_pkg::STATUS_ADDED;
                end
            end
            awaited.push_back(r);
            query.delete();
            overlong = 0;
        endfunction

        function void check_result(logic [olit_pkg::INDEX_W-1:0] index,
                                   logic [olit_pkg::STATUS_W-1:0] code);
            intern_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with none expected: list_index %0d status %0d",
                         $time, index, code);
                return;
            end
            want = awaited.pop_front();
            if (!$isunknown(code)) tally[code]++;
            if (code !== want.code)
            begin
                errors++;
                $display("%0t: status expected %0d, actual %0d", $time, want.code, code);
            end
            if (index !== want.index)
            begin
                errors++;
                $display("%0t: list_index expected %0d, actual %0d", $time, want.index, index);
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             query_valid;
    logic                             query_ready;
    logic [olit_pkg::SITE_W-1:0]      site_number;
    logic                             last;
    logic                             result_valid;
    logic                             result_ready;
    logic [olit_pkg::INDEX_W-1:0]     list_index;
    logic [olit_pkg::STATUS_W-1:0]    status;
    logic                             num_sites_we;
    logic [olit_pkg::NUM_SITES_W-1:0] num_sites;

    intern_scoreboard sb = new();
    bit               quiet;

    // list being sent, and a library of earlier lists for repeats
    logic [olit_pkg::SITE_W-1:0] cur [LONGEST_LIST];
    int                          cur_len;
    logic [olit_pkg::SITE_W-1:0] lib_elems [LIB_DEPTH][MAX_ELEMS];
    int                          lib_len [LIB_DEPTH];
    int                          lib_count;
    int                          lib_next;

    ordered_list_intern_table #(
        .MAX_LISTS (MAX_LISTS),
        .MAX_ELEMS (MAX_ELEMS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .site_number  (site_number),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .list_index   (list_index),
        .status       (status),
        .num_sites_we (num_sites_we),
        .num_sites    (num_sites)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("ordered_list_intern_table regression: fail");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task send_element(input logic [olit_pkg::SITE_W-1:0] site, input logic closes);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_valid <= 1'b1;
        site_number <= site;
        last        <= closes;
        do @(posedge clk); while (!query_ready);
        sb.note_element(site, closes);
    endtask

    task send_list();
        for (int i = 0; i < cur_len; i++)
            send_element(cur[i], i == cur_len - 1);
    endtask

    // register write only once the table has gone quiet
    task write_sites(input logic [olit_pkg::NUM_SITES_W-1:0] value);
        query_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        num_sites_we <= 1'b1;
        num_sites    <= value;
        sb.sites = value;
        @(posedge clk);
        num_sites_we <= 1'b0;
    endtask

    task copy_from_library(input int src);
        cur_len = lib_len[src];
        for (int i = 0; i < cur_len; i++) cur[i] = lib_elems[src][i];
    endtask

    task make_random_list();
        int pick;
        int src;
        int n;
        int k;
        pick = $urandom_range(0, 99);
        src  = (lib_count > 0) ? $urandom_range(0, lib_count - 1) : 0;
        if (lib_count == 0 && (pick < 35 || (pick >= 50 && pick < 72))) pick = 80;
        if (pick < 35)
            copy_from_library(src);
        else if (pick < 50)
        begin
            // around the default entry, one element either side
            n = (sb.sites > MAX_ELEMS) ? MAX_ELEMS : int'(sb.sites);
            cur_len = n + $urandom_range(0, 2) - 1;
            if (cur_len < 1) cur_len = 1;
            if (cur_len > MAX_ELEMS) cur_len = MAX_ELEMS;
            for (int i = 0; i < cur_len; i++) cur[i] = olit_pkg::SITE_W'(i + 1);
        end
        else if (pick < 62)
        begin
            // near miss: one element changed
            copy_from_library(src);
            k = $urandom_range(0, cur_len - 1);
            cur[k] = olit_pkg::SITE_W'($urandom_range(0, 255));
        end
        else if (pick < 72)
        begin
            // near miss: length differs by one
            copy_from_library(src);
            if (cur_len < MAX_ELEMS && ($urandom_range(0, 1) == 1 || cur_len == 1))
            begin
                cur[cur_len] = olit_pkg::SITE_W'($urandom_range(0, 255));
                cur_len++;
            end
            else
                cur_len--;
        end
        else
        begin
            if (pick < 86)
                cur_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_ELEMS)
                                                      : $urandom_range(1, 4);
            else if (pick < 93)
                cur_len = $urandom_range(MAX_ELEMS + 1, LONGEST_LIST);
            else
                cur_len = MAX_ELEMS;
            for (int i = 0; i < cur_len; i++)
                cur[i] = olit_pkg::SITE_W'($urandom_range(0, 255));
        end
        if (pick >= 35 && cur_len <= MAX_ELEMS)
        begin
            lib_len[lib_next] = cur_len;
            for (int i = 0; i < cur_len; i++) lib_elems[lib_next][i] = cur[i];
            lib_next = (lib_next + 1) % LIB_DEPTH;
            if (lib_count < LIB_DEPTH) lib_count++;
        end
    endtask

    function logic [olit_pkg::NUM_SITES_W-1:0] phase_setting(int p);
        case (p)
            0:       return 5'd16;
            1:       return 5'd0;
            2:       return 5'd31;
            3:       return 5'd2;
            4:       return olit_pkg::NUM_SITES_W'($urandom_range(3, 15));
            5:       return 5'd1;
            6:       return olit_pkg::NUM_SITES_W'($urandom_range(0, 31));
            default: return 5'd8;
        endcase
    endfunction

    // result side: random back-pressure, checking every transaction
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready === 1'b1)
                sb.check_result(list_index, status);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 99) < 15) stall = idle_len();
            end
        end
    end

    initial
    begin
        int phase_items;
        int budget;
        query_valid  <= 1'b0;
        site_number  <= '0;
        last         <= 1'b0;
        result_ready <= 1'b0;
        num_sites_we <= 1'b0;
        num_sites    <= '0;
        rst_n        <= 1'b0;
        quiet = 0;
        lib_count = 0;
        lib_next = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_sites(5'd1);

        // directed: default entry, zero and top values, repeat, length, overlong
        send_element(8'd1, 1'b1);
        send_element(8'd0, 1'b1);
        send_element(8'hFF, 1'b1);
        send_element(8'd0, 1'b1);
        send_element(8'd1, 1'b0);
        send_element(8'd2, 1'b1);
        for (int i = 0; i <= MAX_ELEMS; i++)
            send_element(olit_pkg::SITE_W'(i + 1), i == MAX_ELEMS);

        // random lists across several num_sites settings
        budget = RANDOM_ITEMS / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_sites(phase_setting(p));
            phase_items = 0;
            while (phase_items < budget)
            begin
                quiet = ($urandom_range(0, 4) == 0);
                make_random_list();
                send_list();
                phase_items += cur_len;
            end
        end

        query_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d site elements, num_sites from 0 to 31, %0d table entries in use",
                 sb.elements, sb.entry_total);
        $display("Results: %0d found, %0d added, %0d table full, %0d too long",
                 sb.tally[olit_pkg::STATUS_FOUND], sb.tally[olit_pkg::STATUS_ADDED],
                 sb.tally[olit_pkg::STATUS_FULL], sb.tally[olit_pkg::STATUS_TOO_LONG]);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("ordered_list_intern_table regression: pass");
        else
            $display("ordered_list_intern_table regression: fail");
        $finish;
    end

endmodule
